// ----- hdl/prb_pkg.sv -----
// shared types and constants for the packet ring buffer
`default_nettype none

package prb_pkg;

  localparam int BYTE_W  = 8;
  localparam int STAMP_W = 64;
  localparam int CAP_W   = 16;
  localparam int PLEN_W  = 12;
  localparam int TOTAL_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register index of the blocking mode bit
  localparam logic [0:0] REG_BLOCK_WHEN_FULL = 1'b0;

  // transaction codes for the mode field
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DROP  = 3'd1,
    ST_WAIT  = 3'd2,
    ST_LONG  = 3'd3,
    ST_EMPTY = 3'd4,
    ST_CAP   = 3'd5
  } status_t;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_EXEC = 1'b1
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/prb_ctrl.sv -----
// controller state machine for the packet ring buffer
`default_nettype none

module prb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire prb_pkg::sts_t  sts,
  output prb_pkg::cmd_t       cmd
);
  import prb_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTRL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CTRL_IDLE: begin
        if (in_valid) begin
          state_next = CTRL_EXEC;
        end
      end
      CTRL_EXEC: begin
        if (sts.out_free) begin
          state_next = CTRL_IDLE;
        end
      end
      default: state_next = CTRL_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    case (state)
      CTRL_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      CTRL_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/prb_datapath.sv -----
// datapath of the packet ring buffer: pointers, stores, counters, result register
`default_nettype none

module prb_datapath #(
  parameter int SLOTS     = 16,
  parameter int MAX_BYTES = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire prb_pkg::cmd_t                 cmd,
  output prb_pkg::sts_t                      sts,
  input  wire logic                          block_when_full,
  input  wire logic                          mode,
  input  wire logic [prb_pkg::BYTE_W-1:0]    data_byte,
  input  wire logic                          last_byte,
  input  wire logic [prb_pkg::STAMP_W-1:0]   timestamp_in,
  input  wire logic [prb_pkg::CAP_W-1:0]     out_capacity,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output prb_pkg::status_t                   status,
  output logic [prb_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_last,
  output logic [prb_pkg::PLEN_W-1:0]         packet_length,
  output logic [prb_pkg::STAMP_W-1:0]        timestamp_out,
  output logic [prb_pkg::TOTAL_W-1:0]        drop_count,
  output logic [prb_pkg::TOTAL_W-1:0]        wait_count,
  output logic [prb_pkg::TOTAL_W-1:0]        enqueued_count,
  output logic [prb_pkg::TOTAL_W-1:0]        dequeued_count
);
  import prb_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int PTR_W  = SLOT_W + 1;
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);
  localparam int DEPTH  = SLOTS * MAX_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_BYTES);
  localparam logic [ADDR_W-1:0] SLOT_SPAN = ADDR_W'(MAX_BYTES);

  // memories
  logic [BYTE_W-1:0]  packet_store [DEPTH];
  logic [CNT_W-1:0]   length_table [SLOTS];
  logic [STAMP_W-1:0] stamp_table  [SLOTS];

  logic [BYTE_W-1:0]  store_rdata;
  logic [CNT_W-1:0]   len_rdata;
  logic [STAMP_W-1:0] stamp_rdata;

  // ring state
  logic [PTR_W-1:0]   read_pointer;
  logic [PTR_W-1:0]   write_pointer;
  logic [CNT_W-1:0]   write_count;
  logic [CNT_W-1:0]   read_offset;
  logic               refusing;
  status_t            refuse_code;
  logic [TOTAL_W-1:0] drop_total;
  logic [TOTAL_W-1:0] wait_total;
  logic [TOTAL_W-1:0] enq_total;
  logic [TOTAL_W-1:0] deq_total;

  // held transaction
  logic               mode_q;
  logic [BYTE_W-1:0]  data_q;
  logic               last_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [CAP_W-1:0]   cap_q;

  logic [PTR_W-1:0]   read_pointer_next;
  logic [PTR_W-1:0]   write_pointer_next;
  logic [CNT_W-1:0]   write_count_next;
  logic [CNT_W-1:0]   read_offset_next;
  logic               refusing_next;
  status_t            refuse_code_next;
  logic [TOTAL_W-1:0] drop_total_next;
  logic [TOTAL_W-1:0] wait_total_next;
  logic [TOTAL_W-1:0] enq_total_next;
  logic [TOTAL_W-1:0] deq_total_next;

  status_t            res_status;
  logic [BYTE_W-1:0]  res_byte;
  logic               res_last;
  logic [PLEN_W-1:0]  res_len;
  logic [STAMP_W-1:0] res_stamp;

  logic               store_we;
  logic               commit_we;

  logic [SLOT_W-1:0]  wr_slot;
  logic [SLOT_W-1:0]  rd_slot;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CNT_W-1:0]   write_count_inc;
  logic [CNT_W:0]     read_offset_inc;

  logic ring_full;
  logic ring_empty;
  logic start_full;
  logic refuse_a;
  status_t code_a;
  logic too_long;
  logic refuse_b;
  status_t code_b;
  logic [CNT_W-1:0] wc_b;

  assign wr_slot = write_pointer[SLOT_W-1:0];
  assign rd_slot = read_pointer[SLOT_W-1:0];
  assign wr_addr = ADDR_W'(wr_slot) * SLOT_SPAN + ADDR_W'(write_count);
  assign rd_addr = ADDR_W'(rd_slot) * SLOT_SPAN + ADDR_W'(read_offset);

  assign ring_full  = (write_pointer[SLOT_W] != read_pointer[SLOT_W]) &&
                      (write_pointer[SLOT_W-1:0] == read_pointer[SLOT_W-1:0]);
  assign ring_empty = (write_pointer == read_pointer);

  assign write_count_inc = write_count + CNT_W'(1);
  assign read_offset_inc = {1'b0, read_offset} + (CNT_W + 1)'(1);

  assign sts.out_free = !out_valid || !out_stall;

  // refusal decisions for an enqueue byte
  always_comb begin
    start_full = !refusing && (write_count == '0) && ring_full;
    refuse_a   = refusing || start_full;
    code_a     = refuse_code;
    if (start_full) begin
      code_a = block_when_full ? ST_WAIT : ST_DROP;
    end
    too_long = !refuse_a && (write_count >= MAX_CNT);
    refuse_b = refuse_a || too_long;
    code_b   = too_long ? ST_LONG : code_a;
    wc_b     = too_long ? '0 : write_count;
  end

  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    write_count_next   = write_count;
    read_offset_next   = read_offset;
    refusing_next      = refusing;
    refuse_code_next   = refuse_code;
    drop_total_next    = drop_total;
    wait_total_next    = wait_total;
    enq_total_next     = enq_total;
    deq_total_next     = deq_total;
    res_status         = ST_OK;
    res_byte           = '0;
    res_last           = 1'b0;
    res_len            = '0;
    res_stamp          = '0;
    store_we           = 1'b0;
    commit_we          = 1'b0;

    if (mode_q == MODE_ENQ) begin
      if (start_full) begin
        if (block_when_full) begin
          wait_total_next = wait_total + TOTAL_W'(1);
        end else begin
          drop_total_next = drop_total + TOTAL_W'(1);
        end
      end
      if (refuse_b) begin
        res_status       = code_b;
        write_count_next = wc_b;
        if (last_q) begin
          refusing_next    = 1'b0;
          refuse_code_next = ST_OK;
        end else begin
          refusing_next    = 1'b1;
          refuse_code_next = code_b;
        end
      end else begin
        store_we         = 1'b1;
        write_count_next = write_count_inc;
        if (last_q) begin
          commit_we          = 1'b1;
          write_pointer_next = write_pointer + PTR_W'(1);
          write_count_next   = '0;
          enq_total_next     = enq_total + TOTAL_W'(1);
          res_last           = 1'b1;
        end
      end
    end else if (ring_empty) begin
      res_status = ST_EMPTY;
    end else begin
      res_len   = PLEN_W'(len_rdata);
      res_stamp = stamp_rdata;
      if ((read_offset == '0) && (cap_q < CAP_W'(len_rdata))) begin
        res_status = ST_CAP;
      end else begin
        res_byte         = store_rdata;
        read_offset_next = read_offset_inc[CNT_W-1:0];
        if (read_offset_inc >= {1'b0, len_rdata}) begin
          res_last          = 1'b1;
          read_offset_next  = '0;
          read_pointer_next = read_pointer + PTR_W'(1);
          deq_total_next    = deq_total + TOTAL_W'(1);
        end
      end
    end
  end

  // packet bytes: written on an executed enqueue, read at acceptance
  always_ff @(posedge clk) begin
    if (cmd.exec && store_we) begin
      packet_store[wr_addr] <= data_q;
    end
    if (cmd.accept) begin
      store_rdata <= packet_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && commit_we) begin
      length_table[wr_slot] <= write_count_inc;
      stamp_table[wr_slot]  <= stamp_q;
    end
    if (cmd.accept) begin
      len_rdata   <= length_table[rd_slot];
      stamp_rdata <= stamp_table[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q  <= mode;
      data_q  <= data_byte;
      last_q  <= last_byte;
      stamp_q <= timestamp_in;
      cap_q   <= out_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      write_count   <= '0;
      read_offset   <= '0;
      refusing      <= 1'b0;
      refuse_code   <= ST_OK;
      drop_total    <= '0;
      wait_total    <= '0;
      enq_total     <= '0;
      deq_total     <= '0;
    end else if (cmd.exec) begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      write_count   <= write_count_next;
      read_offset   <= read_offset_next;
      refusing      <= refusing_next;
      refuse_code   <= refuse_code_next;
      drop_total    <= drop_total_next;
      wait_total    <= wait_total_next;
      enq_total     <= enq_total_next;
      deq_total     <= deq_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status         <= res_status;
      out_byte       <= res_byte;
      out_last       <= res_last;
      packet_length  <= res_len;
      timestamp_out  <= res_stamp;
      drop_count     <= drop_total_next;
      wait_count     <= wait_total_next;
      enqueued_count <= enq_total_next;
      dequeued_count <= deq_total_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/packet_ring_buffer.sv -----
// top level of the packet ring buffer: config register, controller and datapath
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    mode data_byte last_byte timestamp_in out_capacity
//  out      source     out_valid / out_stall  status out_byte out_last packet_length
//                                             timestamp_out drop/wait/enqueued/dequeued_count
//  cfg      apb slave  psel penable pwrite    paddr pwdata prdata pready
//
//  every transaction has an accept step and an execute step: the accept edge
//  issues the registered reads of the byte store and the length/stamp tables,
//  the execute edge updates the ring and loads the result register
//  a new transaction is taken while a result still waits in the output register;
//  the execute step holds while that register is occupied and stalled
//  synchronous reset clears pointers, refusal state and counters; the stores
//  need no clearing
`default_nettype none

module packet_ring_buffer #(
  parameter int SLOTS     = 16,
  parameter int MAX_BYTES = 2048
) (
  input  wire logic                             clk,
  input  wire logic                             rst,

  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [prb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [prb_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [prb_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,

  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             mode,
  input  wire logic [prb_pkg::BYTE_W-1:0]       data_byte,
  input  wire logic                             last_byte,
  input  wire logic [prb_pkg::STAMP_W-1:0]      timestamp_in,
  input  wire logic [prb_pkg::CAP_W-1:0]        out_capacity,

  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output prb_pkg::status_t                      status,
  output logic      [prb_pkg::BYTE_W-1:0]       out_byte,
  output logic                                  out_last,
  output logic      [prb_pkg::PLEN_W-1:0]       packet_length,
  output logic      [prb_pkg::STAMP_W-1:0]      timestamp_out,
  output logic      [prb_pkg::TOTAL_W-1:0]      drop_count,
  output logic      [prb_pkg::TOTAL_W-1:0]      wait_count,
  output logic      [prb_pkg::TOTAL_W-1:0]      enqueued_count,
  output logic      [prb_pkg::TOTAL_W-1:0]      dequeued_count
);
  import prb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // blocking mode register, one word at byte address zero
  logic block_when_full;
  logic cfg_write;
  logic cfg_hit;

  assign pready    = 1'b1;
  // register index sits above the byte offset bits
  assign cfg_hit   = (paddr[CFG_ADDR_W-1:2] == REG_BLOCK_WHEN_FULL);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_when_full <= 1'b0;
    end else if (cfg_write && cfg_hit) begin
      block_when_full <= pwdata[0];
    end
  end

  // read back, other addresses read as zero
  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata[0] = block_when_full;
    end
  end

  prb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  prb_datapath #(
    .SLOTS     (SLOTS),
    .MAX_BYTES (MAX_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .block_when_full (block_when_full),
    .mode            (mode),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .timestamp_in    (timestamp_in),
    .out_capacity    (out_capacity),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .packet_length   (packet_length),
    .timestamp_out   (timestamp_out),
    .drop_count      (drop_count),
    .wait_count      (wait_count),
    .enqueued_count  (enqueued_count),
    .dequeued_count  (dequeued_count)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// self-checking testbench for the packet ring buffer
`timescale 1ns / 1ps

module tb;
  import prb_pkg::*;

  localparam int SLOTS     = 16;
  localparam int MAX_BYTES = 2048;

  localparam logic [CFG_ADDR_W-1:0] BLOCK_REG_ADDR = CFG_ADDR_W'(4 * REG_BLOCK_WHEN_FULL);

  // cycles with no transaction on any port before the run is called hung
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  in_valid;
  logic                  in_stall;
  logic                  mode;
  logic [BYTE_W-1:0]     data_byte;
  logic                  last_byte;
  logic [STAMP_W-1:0]    timestamp_in;
  logic [CAP_W-1:0]      out_capacity;

  logic                  out_valid;
  logic                  out_stall;
  status_t               status;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_last;
  logic [PLEN_W-1:0]     packet_length;
  logic [STAMP_W-1:0]    timestamp_out;
  logic [TOTAL_W-1:0]    drop_count;
  logic [TOTAL_W-1:0]    wait_count;
  logic [TOTAL_W-1:0]    enqueued_count;
  logic [TOTAL_W-1:0]    dequeued_count;

  packet_ring_buffer #(
    .SLOTS     (SLOTS),
    .MAX_BYTES (MAX_BYTES)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .timestamp_in   (timestamp_in),
    .out_capacity   (out_capacity),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .packet_length  (packet_length),
    .timestamp_out  (timestamp_out),
    .drop_count     (drop_count),
    .wait_count     (wait_count),
    .enqueued_count (enqueued_count),
    .dequeued_count (dequeued_count)
  );

  // one input transaction as the ring sees it
  typedef struct {
    logic              mode;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [STAMP_W-1:0] stamp;
    logic [CAP_W-1:0]  cap;
  } ring_op_t;

  // one output transaction: status, read data and the four totals
  typedef struct {
    status_t            st;
    logic [BYTE_W-1:0]  obyte;
    logic               olast;
    logic [PLEN_W-1:0]  plen;
    logic [STAMP_W-1:0] stamp;
    logic [TOTAL_W-1:0] drops;
    logic [TOTAL_W-1:0] waits;
    logic [TOTAL_W-1:0] enqs;
    logic [TOTAL_W-1:0] deqs;
  } ring_reply_t;

  // mirror of the ring: slot storage, free-running pointers over 2*SLOTS values
  logic [BYTE_W-1:0]  slot_bytes [SLOTS][MAX_BYTES];
  logic [PLEN_W-1:0]  slot_len   [SLOTS];
  logic [STAMP_W-1:0] slot_stamp [SLOTS];
  logic [4:0]         rd_ptr;
  logic [4:0]         wr_ptr;
  int                 wr_fill;     // bytes of the packet being written
  int                 rd_pos;      // read offset inside the head packet
  logic               refusing_now;
  status_t            refusal_code;
  logic               block_mode;
  logic [TOTAL_W-1:0] drop_tot;
  logic [TOTAL_W-1:0] wait_tot;
  logic [TOTAL_W-1:0] enq_tot;
  logic [TOTAL_W-1:0] deq_tot;

  // replies still owed by the block, oldest first
  ring_reply_t pending_replies[$];

  int fail_count;
  int n_sent;
  int n_checked;
  int n_cap;
  int n_long;
  int burst_left;
  bit steady;        // sender keeps valid up with no gaps
  int idle_cycles;

  // advance the ring mirror by one transaction and return the reply it causes
  function automatic ring_reply_t ring_step(ring_op_t op);
    ring_reply_t r;
    int slot;
    int len;
    r.st    = ST_OK;
    r.obyte = '0;
    r.olast = 1'b0;
    r.plen  = '0;
    r.stamp = '0;
    if (op.mode == MODE_ENQ) begin
      // a packet whose first byte meets a full ring is refused as a whole
      if (!refusing_now && wr_fill == 0 && 5'(wr_ptr - rd_ptr) == 5'(SLOTS)) begin
        refusing_now = 1'b1;
        if (block_mode) begin
          refusal_code = ST_WAIT;
          wait_tot++;
        end else begin
          refusal_code = ST_DROP;
          drop_tot++;
        end
      end
      // one byte past the maximum throws the partial packet away
      if (!refusing_now && wr_fill >= MAX_BYTES) begin
        refusing_now = 1'b1;
        refusal_code = ST_LONG;
        wr_fill      = 0;
      end
      if (refusing_now) begin
        r.st = refusal_code;
        if (op.last) begin
          refusing_now = 1'b0;
          refusal_code = ST_OK;
        end
      end else begin
        slot = int'(wr_ptr) % SLOTS;
        slot_bytes[slot][wr_fill] = op.data;
        wr_fill++;
        if (op.last) begin
          slot_len[slot]   = PLEN_W'(wr_fill);
          slot_stamp[slot] = op.stamp;
          wr_ptr           = wr_ptr + 5'd1;
          wr_fill          = 0;
          enq_tot++;
          r.olast = 1'b1;
        end
      end
    end else if (rd_ptr == wr_ptr) begin
      r.st = ST_EMPTY;
    end else begin
      slot    = int'(rd_ptr) % SLOTS;
      len     = int'(slot_len[slot]);
      r.plen  = slot_len[slot];
      r.stamp = slot_stamp[slot];
      // capacity only matters before the first byte of the packet
      if (rd_pos == 0 && int'(op.cap) < len) begin
        r.st = ST_CAP;
      end else begin
        r.obyte = slot_bytes[slot][rd_pos];
        rd_pos++;
        if (rd_pos >= len) begin
          r.olast = 1'b1;
          rd_pos  = 0;
          rd_ptr  = rd_ptr + 5'd1;
          deq_tot++;
        end
      end
    end
    r.drops = drop_tot;
    r.waits = wait_tot;
    r.enqs  = enq_tot;
    r.deqs  = deq_tot;
    return r;
  endfunction

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // drive one transaction into the block; the sender runs in bursts with gaps
  // between them, and valid stays up from one item to the next inside a burst
  task automatic send_item(input logic m, input logic [BYTE_W-1:0] d, input logic l,
                           input logic [STAMP_W-1:0] ts, input logic [CAP_W-1:0] cap);
    ring_op_t    op;
    ring_reply_t r;
    int          gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    op.mode  = m;
    op.data  = d;
    op.last  = l;
    op.stamp = ts;
    op.cap   = cap;
    in_valid     <= 1'b1;
    mode         <= m;
    data_byte    <= d;
    last_byte    <= l;
    timestamp_in <= ts;
    out_capacity <= cap;
    // payload holds until the edge that takes it
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = ring_step(op);
    pending_replies.push_back(r);
    if (r.st == ST_CAP) n_cap++;
    if (r.st == ST_LONG && l) n_long++;
    n_sent++;
    burst_left--;
  endtask

  // enqueue one byte; fields an enqueue ignores still carry random values
  task automatic enq(input logic [BYTE_W-1:0] d, input logic l, input logic [STAMP_W-1:0] ts);
    send_item(MODE_ENQ, d, l, ts, CAP_W'($urandom));
  endtask

  task automatic deq(input logic [CAP_W-1:0] cap);
    send_item(MODE_DEQ, BYTE_W'($urandom), 1'($urandom), {$urandom, $urandom}, cap);
  endtask

  // a whole packet of random bytes
  task automatic enq_packet(input int len);
    for (int i = 0; i < len; i++) begin
      enq(BYTE_W'($urandom), i == len - 1, {$urandom, $urandom});
    end
  endtask

  // stop sending and let every owed reply drain out before touching the register
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write of block_when_full followed by a read back
  task automatic set_blocking(input logic val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= BLOCK_REG_ADDR;
    pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    block_mode = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DATA_W'(val)) begin
      fail_count++;
      if (fail_count <= 10)
        $display("register read back: wrote %0d, got %h", val, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // mostly random 16-bit capacities, some tiny ones to trip the size check
  function automatic logic [CAP_W-1:0] random_cap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return CAP_W'($urandom_range(0, 6));
    if (roll < 20) return '1;
    return CAP_W'($urandom);
  endfunction

  // reads on an empty ring, an uncommitted packet that stays invisible,
  // capacity refusals and reads that run through the middle of a packet
  task automatic test_basic_traffic();
    deq('0);
    deq('1);
    enq(8'h00, 1'b0, {$urandom, $urandom});
    deq('1);                              // half-written packet is not visible
    enq(8'hff, 1'b0, {$urandom, $urandom});
    enq(8'ha5, 1'b1, '1);
    enq(8'h5a, 1'b1, '0);
    deq('0);                              // capacity 0 against length 3
    deq(16'd2);                           // one short of the length
    deq(16'd3);
    deq('0);                              // mid-packet, capacity no longer checked
    deq(16'd1);
    deq('0);                              // 1-byte packet, capacity 0 refused
    deq('1);
    deq(16'd7);
    settle();
  endtask

  // fill the ring, refuse in both modes, switch modes with a refusal latched
  task automatic test_full_ring();
    set_blocking(1'b0);
    for (int i = 0; i < SLOTS; i++) enq(BYTE_W'($urandom), 1'b1, {$urandom, $urandom});
    enq_packet(3);                        // dropped, one drop counted
    enq(BYTE_W'($urandom), 1'b0, {$urandom, $urandom});
    enq(BYTE_W'($urandom), 1'b0, {$urandom, $urandom});
    settle();
    set_blocking(1'b1);
    // the drop code latched at the start of this packet still applies
    enq(BYTE_W'($urandom), 1'b1, {$urandom, $urandom});
    enq_packet(2);                        // refused as wait now
    deq('1);
    enq(BYTE_W'($urandom), 1'b1, {$urandom, $urandom});
    for (int i = 0; i < SLOTS; i++) deq('1);
    deq('1);
    settle();
  endtask

  // random packets and read runs; the enqueue weight decides whether the
  // ring tends to fill up or drain
  task automatic test_random_phase(input logic blocking, input int quota, input int enq_weight);
    int start;
    int roll;
    int len;
    set_blocking(blocking);
    start = n_sent;
    steady = ($urandom_range(0, 3) == 0);
    while (n_sent - start < quota) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // stray byte with a random end mark
        enq(BYTE_W'($urandom), 1'($urandom), {$urandom, $urandom});
      end else if (roll < enq_weight) begin
        roll = $urandom_range(0, 99);
        len = (roll < 80) ? $urandom_range(1, 8) :
              (roll < 96) ? $urandom_range(9, 40) : $urandom_range(41, 160);
        for (int i = 0; i < len; i++) begin
          enq(BYTE_W'($urandom), i == len - 1, {$urandom, $urandom});
          if ($urandom_range(0, 99) < 15) deq(random_cap());
        end
      end else begin
        repeat ($urandom_range(1, 6)) deq(random_cap());
      end
    end
    steady = 1'b0;
    settle();
  endtask

  // result side: compare every taken reply with the oldest one owed, and
  // stall in styles that change every so often
  initial begin
    int          style;
    int          style_left;
    int          tick;
    ring_reply_t want;
    out_stall <= 1'b0;
    style      = 0;
    style_left = 100;
    tick       = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("reply with none owed: status %0d", status);
        end else begin
          want = pending_replies.pop_front();
          n_checked++;
          if (status !== want.st || out_byte !== want.obyte || out_last !== want.olast ||
              packet_length !== want.plen || timestamp_out !== want.stamp ||
              drop_count !== want.drops || wait_count !== want.waits ||
              enqueued_count !== want.enqs || dequeued_count !== want.deqs) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("reply %0d exp st=%0d byte=%h last=%b len=%0d ts=%h %0d/%0d/%0d/%0d",
                       n_checked, want.st, want.obyte, want.olast, want.plen, want.stamp,
                       want.drops, want.waits, want.enqs, want.deqs);
              $display("          got st=%0d byte=%h last=%b len=%0d ts=%h %0d/%0d/%0d/%0d",
                       status, out_byte, out_last, packet_length, timestamp_out,
                       drop_count, wait_count, enqueued_count, dequeued_count);
            end
          end
        end
      end
      tick++;
      style_left--;
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(40, 200);
      end
      case (style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (tick % 8 < 3);
      endcase
    end
  end

  // watchdog: any accepted transaction or config access restarts the count
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  // test sequence
  initial begin
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid     <= 1'b0;
    mode         <= MODE_ENQ;
    data_byte    <= '0;
    last_byte    <= 1'b0;
    timestamp_in <= '0;
    out_capacity <= '0;
    rst          <= 1'b1;

    // mirror starts from the reset state
    rd_ptr       = '0;
    wr_ptr       = '0;
    wr_fill      = 0;
    rd_pos       = 0;
    refusing_now = 1'b0;
    refusal_code = ST_OK;
    block_mode   = 1'b0;
    drop_tot     = '0;
    wait_tot     = '0;
    enq_tot      = '0;
    deq_tot      = '0;
    fail_count   = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_cap        = 0;
    n_long       = 0;
    burst_left   = 0;
    steady       = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_traffic();
    test_full_ring();
    // fill-heavy phases in both blocking modes, drain-heavy ones in non-blocking mode only
    test_random_phase(1'b0, 100, 70);
    test_random_phase(1'b1, 100, 70);
    test_random_phase(1'b0, 100, 35);
    test_random_phase(1'b1, 100, 55);
    test_random_phase(1'b1, 100, 80);
    test_random_phase(1'b0, 100, 45);

    // settle() already drained everything; let the pipeline run idle before the summary
    repeat (8) @(posedge clk);

    $display("covered %0d transactions in, %0d replies checked, %0d committed, %0d read out",
             n_sent, n_checked, enq_tot, deq_tot);
    $display("refusals seen: %0d dropped, %0d wait, %0d too long, %0d capacity",
             drop_tot, wait_tot, n_long, n_cap);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/prb_pkg.sv
hdl/prb_ctrl.sv
hdl/prb_datapath.sv
hdl/packet_ring_buffer.sv
dv/tb.sv
